// ===== design/amx_pkg.sv =====
package amx_pkg;

	// Sizes of the command and result fields.
	localparam int MAX_VERTICES_DEF = 8;
	localparam int CNT_W = 4;
	localparam int VTX_W = 3;
	localparam int CMD_W = 3;
	localparam int STAT_W = 3;
	localparam int DATA_W = 16;

	// Configuration port sizes.
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// Register indexes on the configuration port.
	localparam logic REG_VERTEX_COUNT = 1'b0;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_SET = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LIST = 3'd2;
	localparam logic [CMD_W-1:0] CMD_PRED = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SUCC = 3'd4;
	localparam logic [CMD_W-1:0] CMD_TEST = 3'd5;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_ACK = 3'd0;
	localparam logic [STAT_W-1:0] STAT_ENTRY = 3'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 3'd2;
	localparam logic [STAT_W-1:0] STAT_PRESENT = 3'd3;
	localparam logic [STAT_W-1:0] STAT_ABSENT = 3'd4;
	localparam logic [STAT_W-1:0] STAT_BAD = 3'd5;

	// One result beat.
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VTX_W-1:0] from_vertex;
		logic [VTX_W-1:0] to_vertex;
		logic last;
	} result_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MODIFY = 5'b00010,
		S_REPLY = 5'b00100,
		S_SCAN = 5'b01000,
		S_FLUSH = 5'b10000
	} state_t;

endpackage

// ===== design/amx_row_mem.sv =====
module amx_row_mem
	import amx_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
	output logic [MAX_VERTICES-1:0] rd_data,
	input logic wr_en,
	input logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
	input logic [MAX_VERTICES-1:0] wr_data
);

	logic [MAX_VERTICES-1:0] mem_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_valid_q;

	// A row reads as empty until it has been written once since reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[wr_addr] <= 1'b1;
		end
	end

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= row_valid_q[rd_addr] ? mem_q[rd_addr] : '0;
		end
	end

endmodule

// ===== design/amx_ctrl.sv =====
module amx_ctrl
	import amx_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic [CNT_W-1:0] vertex_count,
	input logic in_valid,
	output logic in_ready,
	input logic [CMD_W-1:0] command,
	input logic [VTX_W-1:0] vertex_a,
	input logic [VTX_W-1:0] vertex_b,
	output logic emit_valid,
	output result_t emit,
	input logic out_free,
	output logic rd_en,
	output logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
	input logic [MAX_VERTICES-1:0] rd_data,
	output logic wr_en,
	output logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
	output logic [MAX_VERTICES-1:0] wr_data
);

	localparam int CW = $clog2(MAX_VERTICES);

	state_t state_q;
	logic [CMD_W-1:0] cmd_q;
	logic [VTX_W-1:0] a_q;
	logic [VTX_W-1:0] b_q;
	logic [CW-1:0] nm1_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic issue_q;

	logic v_s1;
	logic [CW-1:0] bit_s1;
	logic [VTX_W-1:0] from_s1;
	logic [VTX_W-1:0] to_s1;
	logic final_s1;

	logic pend_valid_q;
	logic [VTX_W-1:0] pend_from_q;
	logic [VTX_W-1:0] pend_to_q;

	logic [CNT_W-1:0] eff_n;
	logic [CNT_W-1:0] eff_m1;
	logic in_bad;
	logic accept;
	logic hit_s1;
	logic advance;
	logic [CW-1:0] a_cw;
	logic [CW-1:0] b_cw;
	logic [CW-1:0] scan_row;
	logic [CW-1:0] scan_bit;
	logic [CW-1:0] scan_from;
	logic [CW-1:0] scan_to;
	logic scan_final;
	logic present;
	logic [MAX_VERTICES-1:0] mask;

	// Count in use, saturated at the matrix size.
	assign eff_n = (vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vertex_count;
	assign eff_m1 = eff_n - CNT_W'(1);

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;

	// Range check of the vertices that each command uses.
	always_comb begin
		unique case (command)
			CMD_SET, CMD_CLEAR, CMD_TEST: begin
				in_bad = (CNT_W'(vertex_a) >= eff_n) || (CNT_W'(vertex_b) >= eff_n);
			end
			CMD_PRED, CMD_SUCC: begin
				in_bad = (CNT_W'(vertex_a) >= eff_n);
			end
			CMD_LIST: begin
				in_bad = 1'b0;
			end
			default: begin
				in_bad = 1'b1;
			end
		endcase
	end

	assign a_cw = a_q[CW-1:0];
	assign b_cw = b_q[CW-1:0];

	// Row, bit and reported edge for the current scan step.
	always_comb begin
		unique case (cmd_q)
			CMD_LIST: begin
				scan_row = i_q;
				scan_bit = j_q;
				scan_from = i_q;
				scan_to = j_q;
				scan_final = (i_q == nm1_q) && (j_q == nm1_q);
			end
			CMD_PRED: begin
				scan_row = j_q;
				scan_bit = a_cw;
				scan_from = j_q;
				scan_to = a_cw;
				scan_final = (j_q == nm1_q);
			end
			default: begin
				scan_row = a_cw;
				scan_bit = j_q;
				scan_from = a_cw;
				scan_to = j_q;
				scan_final = (j_q == nm1_q);
			end
		endcase
	end

	// The scan stalls only when a found entry must push out the pending one.
	assign hit_s1 = v_s1 && rd_data[bit_s1];
	assign advance = !(hit_s1 && pend_valid_q && !out_free);

	// Memory read: the addressed row on a single-edge command, else the scan row.
	assign rd_en = (accept && !in_bad &&
		(command == CMD_SET || command == CMD_CLEAR || command == CMD_TEST)) ||
		(state_q == S_SCAN && issue_q && advance);
	assign rd_addr = (state_q == S_IDLE) ? vertex_a[CW-1:0] : scan_row;

	// Read-modify-write of one row for set and clear.
	assign mask = MAX_VERTICES'(1) << b_cw;
	assign present = rd_data[b_cw];
	assign wr_en = (state_q == S_MODIFY) && out_free && (cmd_q != CMD_TEST);
	assign wr_addr = a_cw;
	assign wr_data = (cmd_q == CMD_SET) ? (rd_data | mask) : (rd_data & ~mask);

	// Result beat offered to the output register.
	always_comb begin
		emit_valid = 1'b0;
		emit = '0;
		unique case (state_q)
			S_REPLY: begin
				emit_valid = 1'b1;
				emit = '{status: STAT_BAD, from_vertex: a_q, to_vertex: b_q, last: 1'b1};
			end
			S_MODIFY: begin
				emit_valid = 1'b1;
				emit.status = (cmd_q == CMD_TEST) ?
					(present ? STAT_PRESENT : STAT_ABSENT) : STAT_ACK;
				emit.from_vertex = a_q;
				emit.to_vertex = b_q;
				emit.last = 1'b1;
			end
			S_SCAN: begin
				emit_valid = hit_s1 && pend_valid_q;
				emit = '{status: STAT_ENTRY, from_vertex: pend_from_q,
					to_vertex: pend_to_q, last: 1'b0};
			end
			S_FLUSH: begin
				emit_valid = 1'b1;
				if (pend_valid_q) begin
					emit = '{status: STAT_ENTRY, from_vertex: pend_from_q,
						to_vertex: pend_to_q, last: 1'b1};
				end else begin
					emit = '{status: STAT_EMPTY, from_vertex: '0, to_vertex: '0, last: 1'b1};
				end
			end
			default: begin
				emit_valid = 1'b0;
			end
		endcase
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issue_q <= 1'b0;
			v_s1 <= 1'b0;
			pend_valid_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						i_q <= '0;
						j_q <= '0;
						v_s1 <= 1'b0;
						pend_valid_q <= 1'b0;
						if (in_bad) begin
							state_q <= S_REPLY;
						end else if (command == CMD_LIST || command == CMD_PRED ||
							command == CMD_SUCC) begin
							if (eff_n == '0) begin
								state_q <= S_FLUSH;
							end else begin
								state_q <= S_SCAN;
								issue_q <= 1'b1;
							end
						end else begin
							state_q <= S_MODIFY;
						end
					end
				end
				S_MODIFY, S_REPLY, S_FLUSH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (advance) begin
						// Issue stage: step through the matrix bits.
						v_s1 <= issue_q;
						if (issue_q) begin
							if (scan_final) begin
								issue_q <= 1'b0;
							end else if (j_q == nm1_q) begin
								j_q <= '0;
								i_q <= i_q + CW'(1);
							end else begin
								j_q <= j_q + CW'(1);
							end
						end
						// Test stage: a hit becomes the pending entry.
						if (hit_s1) begin
							pend_valid_q <= 1'b1;
						end
						if (v_s1 && final_s1) begin
							state_q <= S_FLUSH;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command and scan payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			a_q <= vertex_a;
			b_q <= vertex_b;
			nm1_q <= eff_m1[CW-1:0];
		end
		if (state_q == S_SCAN && advance) begin
			if (issue_q) begin
				bit_s1 <= scan_bit;
				from_s1 <= VTX_W'(scan_from);
				to_s1 <= VTX_W'(scan_to);
				final_s1 <= scan_final;
			end
			if (hit_s1) begin
				pend_from_q <= from_s1;
				pend_to_q <= to_s1;
			end
		end
	end

endmodule

// ===== design/adjacency_matrix_engine.sv =====
// Directed-graph adjacency matrix engine.
// Commands arrive as beats on the s_ channel: set edge, clear edge, list all
// edges, list predecessors, list successors and test edge. Results leave on the
// m_ channel, with m_tlast high on the final beat of each command. A list gives
// one entry per edge and ends with its last entry marked, or gives one "list
// empty" beat. Set and clear give one acknowledge, test one present or absent
// beat, and a vertex at or above the vertex count one bad-vertex beat.
// The user writes the vertex count over the APB port at address 0 only while
// idle; the block does not enforce it. Commands are handled one at a time.
// Set and clear read the row, then modify and write it back; test only reads
// it. Predecessor and successor lists scan n bits and the full list n*n bits
// for a vertex count n, one matrix bit per cycle through the row memory's
// read port unless the output stalls the scan. Output beats are held in an
// output register; when it is full, m_tready is low and a further entry is
// found, the scan stalls and no beat is lost. Reset clears the matrix (all rows
// read as empty) and sets the count to 8; no memory clearing pass is needed.
module adjacency_matrix_engine
	import amx_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input logic clk,
	input logic arst_n,
	// Command channel.
	input logic s_tvalid,
	output logic s_tready,
	input logic [DATA_W-1:0] s_tdata, // command[2:0], vertex_a[5:3], vertex_b[8:6]
	// Result channel.
	output logic m_tvalid,
	input logic m_tready,
	output logic [DATA_W-1:0] m_tdata, // status[2:0], from_vertex[5:3], to_vertex[8:6]
	output logic m_tlast,
	// Configuration port.
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [APB_AW-1:0] paddr,
	input logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic pready
);

	localparam int CW = $clog2(MAX_VERTICES);

	logic [CNT_W-1:0] vertex_count_q;
	logic m_valid_q;
	result_t m_data_q;
	logic out_free;
	logic emit_valid;
	result_t emit;
	logic rd_en;
	logic [CW-1:0] rd_addr;
	logic [MAX_VERTICES-1:0] rd_data;
	logic wr_en;
	logic [CW-1:0] wr_addr;
	logic [MAX_VERTICES-1:0] wr_data;

	// Configuration register.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= CNT_W'(8);
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_VERTEX_COUNT) begin
			vertex_count_q <= pwdata[CNT_W-1:0];
		end
	end
	assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? APB_DW'(vertex_count_q) : '0;

	// Output register between the sequencer and the result channel.
	assign out_free = !m_valid_q || m_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= emit_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (out_free && emit_valid) begin
			m_data_q <= emit;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = DATA_W'({m_data_q.to_vertex, m_data_q.from_vertex, m_data_q.status});
	assign m_tlast = m_data_q.last;

	amx_ctrl #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.vertex_count(vertex_count_q),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.command(s_tdata[CMD_W-1:0]),
		.vertex_a(s_tdata[CMD_W+VTX_W-1:CMD_W]),
		.vertex_b(s_tdata[CMD_W+2*VTX_W-1:CMD_W+VTX_W]),
		.emit_valid(emit_valid),
		.emit(emit),
		.out_free(out_free),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	amx_row_mem #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

endmodule
